### src/tkoos_pkg.sv
// Package for the top-k odd octal select block.
// Request and result structs, cell control struct, FSM states and register map.
// No dependencies.
package tkoos_pkg;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               final_item;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] kept_value;
    logic [63:0]        octal_as_decimal;
    logic               none_odd;
    logic               run_end;
  } result_t;

  typedef struct packed {
    logic insert;
    logic mark;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MARK,
    ST_SCAN,
    ST_CONV,
    ST_HOLD
  } state_t;

  localparam int ADDR_W = 3;
  localparam logic REG_SELECT_COUNT = 1'b0;  // paddr[2]
  localparam logic [3:0] SELECT_COUNT_RESET = 4'd6;
  localparam int RESULT_LIMIT = 8;
  localparam int OCT_DIGITS = 22;  // octal digits of a 64-bit word

endpackage

### src/top_k_odd_octal_select.sv
// Top-k odd octal select: keeps the largest values of a stream in a sorted cell chain,
// then emits the odd ones among the first select_count with their octal-as-decimal form.
// Depends on tkoos_pkg, tkoos_cell, tkoos_octal.
//
// Values are accepted one per cycle while loading; each is placed by a chain of
// compare-and-shift cells as it is accepted. After the request marked final, the
// sample side stalls: the mark state flags the entries to examine, then the chain
// shifts toward its head one entry per cycle while the head entry is not pending.
// Each odd entry starts the digit-serial octal converter, which converts all 22
// digits, and is then loaded into the result register once that is free. A run with
// no odd value gives one empty result. The result register decouples the two sides:
// loading resumes while the last result still waits.
module top_k_odd_octal_select #(
  parameter int MAX_KEEP = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  tkoos_pkg::sample_t            sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tkoos_pkg::result_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkoos_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tkoos_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int LIM_CAP = (MAX_KEEP < RESULT_LIMIT) ? MAX_KEEP : RESULT_LIMIT;

  state_t     state, state_next;
  cell_ctrl_t ctrl;
  logic [3:0] select_count;
  logic [CW-1:0] fill_count;
  logic       any_sent;
  logic       accept, out_free, conv_start, conv_done, load_odd, load_empty, leave_run;
  logic       last_odd;
  logic [CW-1:0] sel_cap, limit;
  logic [63:0] conv_acc;

  logic signed [31:0] cell_value [MAX_KEEP];
  logic [MAX_KEEP-1:0] cell_ins, cell_pend;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SELECT_COUNT) ? {28'd0, select_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_count <= SELECT_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SELECT_COUNT) begin
      select_count <= pwdata[3:0];
    end
  end

  assign sample_stall = (state != ST_LOAD);
  assign accept = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;

  assign sel_cap = (32'(select_count) > LIM_CAP) ? CW'(LIM_CAP) : CW'(select_count);
  assign limit = (sel_cap < fill_count) ? sel_cap : fill_count;
  assign last_odd = ((cell_pend >> 1) == '0);

  // cell chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic signed [31:0] prev_v, next_v;
    logic prev_i, next_p;
    if (i == 0) begin : g_head
      assign prev_v = sample.sample_value;
      assign prev_i = 1'b0;
    end else begin : g_mid
      assign prev_v = cell_value[i-1];
      assign prev_i = cell_ins[i-1];
    end
    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_v = cell_value[i];
      assign next_p = 1'b0;
    end else begin : g_body
      assign next_v = cell_value[i+1];
      assign next_p = cell_pend[i+1];
    end
    tkoos_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (sample.sample_value),
      .occupied   (CW'(i) < fill_count),
      .mark_sel   (CW'(i) < limit),
      .prev_value (prev_v),
      .prev_ins   (prev_i),
      .next_value (next_v),
      .next_pend  (next_p),
      .value      (cell_value[i]),
      .ins        (cell_ins[i]),
      .pend       (cell_pend[i])
    );
  end

  tkoos_octal u_octal (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (cell_value[0]),
    .done  (conv_done),
    .acc   (conv_acc)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (accept && sample.final_item) state_next = ST_MARK;
      ST_MARK: state_next = ST_SCAN;
      ST_SCAN: begin
        if (cell_pend == '0) begin
          if (any_sent || out_free) state_next = ST_LOAD;
        end else if (cell_pend[0]) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: if (conv_done) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_SCAN;
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl       = '0;
    conv_start = 1'b0;
    load_odd   = 1'b0;
    load_empty = 1'b0;
    leave_run  = 1'b0;
    case (state)
      ST_LOAD: ctrl.insert = accept;
      ST_MARK: ctrl.mark = 1'b1;
      ST_SCAN: begin
        if (cell_pend == '0) begin
          load_empty = !any_sent && out_free;
          leave_run  = any_sent || out_free;
        end else if (cell_pend[0]) begin
          conv_start = 1'b1;
        end else begin
          ctrl.shift = 1'b1;
        end
      end
      ST_HOLD: begin
        load_odd   = out_free;
        ctrl.shift = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
      any_sent   <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.mark) begin
        fill_count <= '0;
      end else if (ctrl.insert && fill_count < CW'(MAX_KEEP)) begin
        fill_count <= fill_count + CW'(1);
      end
      if (leave_run) begin
        any_sent <= 1'b0;
      end else if (load_odd) begin
        any_sent <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= load_odd || load_empty || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load_odd) begin
      result.kept_value       <= cell_value[0];
      result.octal_as_decimal <= conv_acc;
      result.none_odd         <= 1'b0;
      result.run_end          <= last_odd;
    end else if (load_empty) begin
      result.kept_value       <= '0;
      result.octal_as_decimal <= '0;
      result.none_odd         <= 1'b1;
      result.run_end          <= 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_KEEP))
    else $error("fill count beyond chain length");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    (load_odd && last_odd) |=> (cell_pend == '0))
    else $error("entries still pending after run end");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.none_odd) |->
      (result.kept_value == 0 && result.octal_as_decimal == 0 && result.run_end))
    else $error("empty result carries data");

  a_odd_only: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.none_odd) |-> result.kept_value[0])
    else $error("even value emitted");

  a_conv_head: assert property (@(posedge clk) disable iff (rst)
    conv_start |-> cell_pend[0])
    else $error("conversion started on an entry not pending");

endmodule

### src/tkoos_cell.sv
// One cell of the sorted chain: holds one kept value and its pending flag.
// Inserts by compare-and-shift toward the tail, shifts toward the head when scanning.
// Depends on tkoos_pkg.
module tkoos_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  tkoos_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]    new_value,
  input  logic                  occupied,
  input  logic                  mark_sel,
  input  logic signed [31:0]    prev_value,
  input  logic                  prev_ins,
  input  logic signed [31:0]    next_value,
  input  logic                  next_pend,
  output logic signed [31:0]    value,
  output logic                  ins,
  output logic                  pend
);
  import tkoos_pkg::*;

  assign ins = !occupied || (new_value > value);

  always_ff @(posedge clk) begin
    if (ctrl.insert && ins) begin
      value <= prev_ins ? prev_value : new_value;
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (ctrl.mark) begin
      pend <= mark_sel && value[0];
    end else if (ctrl.shift) begin
      pend <= next_pend;
    end
  end

endmodule

### src/tkoos_octal.sv
// Octal-digits-as-decimal converter, one octal digit per cycle, MSB first.
// acc = acc * 10 + digit over the 22 digits of the sign-extended 64-bit pattern.
// Depends on tkoos_pkg.
module tkoos_octal (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [63:0]        acc
);
  import tkoos_pkg::*;

  localparam int SW = 3 * OCT_DIGITS;
  localparam int CNT_W = $clog2(OCT_DIGITS);

  logic [SW-1:0]    digits;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign done = busy && (cnt == CNT_W'(OCT_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  // top digit holds bit 63 only
  always_ff @(posedge clk) begin
    if (start) begin
      digits <= {{(SW - 64){1'b0}}, {32{value[31]}}, value};
      acc    <= '0;
    end else if (busy) begin
      digits <= {digits[SW-4:0], 3'b000};
      acc    <= (acc << 3) + (acc << 1) + {61'd0, digits[SW-1:SW-3]};
    end
  end

endmodule

### tb/top_k_odd_octal_select_tb.sv
// Testbench for top_k_odd_octal_select: streams runs of signed values, predicts the odd
// survivors of the top select_count with their octal-as-decimal form, checks every result.
// Depends on tkoos_pkg and the top_k_odd_octal_select RTL.
module top_k_odd_octal_select_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkoos_pkg::*;

  localparam int MAX_KEEP = 8;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 40;
  localparam logic [ADDR_W-1:0] SELECT_COUNT_ADDR = {REG_SELECT_COUNT, 2'b00};
  localparam logic [63:0] OCT_RADIX = 64'd8;
  localparam logic [63:0] DEC_RADIX = 64'd10;

  class odd_top_scoreboard;
    logic signed [31:0] kept_list [MAX_KEEP];
    int                 kept_n;
    logic [3:0]         select_count;
    result_t            pending_results [$];
    int                 errors;

    function new();
      kept_n = 0;
      select_count = SELECT_COUNT_RESET;
      errors = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [63:0] octal_as_dec(logic signed [31:0] v);
      logic [63:0] num;
      logic [63:0] sum;
      logic [63:0] place;
      num = {{32{v[31]}}, v};
      sum = 0;
      place = 1;
      while (num != 0) begin
        sum = sum + (num % OCT_RADIX) * place;
        place = place * DEC_RADIX;
        num = num / OCT_RADIX;
      end
      return sum;
    endfunction

    function void note_sample(sample_t s);
      int      pos;
      int      limit;
      int      found;
      result_t r;
      pos = 0;
      while (pos < kept_n && kept_list[pos] >= s.sample_value) pos++;
      if (pos < MAX_KEEP) begin
        if (kept_n < MAX_KEEP) kept_n++;
        for (int i = kept_n - 1; i > pos; i--) kept_list[i] = kept_list[i-1];
        kept_list[pos] = s.sample_value;
      end
      if (!s.final_item) return;
      limit = select_count;
      if (limit > MAX_KEEP) limit = MAX_KEEP;
      if (limit > RESULT_LIMIT) limit = RESULT_LIMIT;
      if (limit > kept_n) limit = kept_n;
      found = 0;
      for (int i = 0; i < limit; i++) begin
        if (kept_list[i][0]) begin
          r.kept_value = kept_list[i];
          r.octal_as_decimal = octal_as_dec(kept_list[i]);
          r.none_odd = 1'b0;
          r.run_end = 1'b0;
          pending_results.push_back(r);
          found++;
        end
      end
      if (found == 0) begin
        r.kept_value = '0;
        r.octal_as_decimal = '0;
        r.none_odd = 1'b1;
        r.run_end = 1'b1;
        pending_results.push_back(r);
      end else begin
        pending_results[pending_results.size()-1].run_end = 1'b1;
      end
      kept_n = 0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kept_value=%0d octal=%0d none_odd=%0b run_end=%0b",
                 $time, got.kept_value, got.octal_as_decimal, got.none_odd, got.run_end);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kept_value !== want.kept_value) begin
        $display("%0t: kept_value expected %0d actual %0d", $time, want.kept_value,
                 got.kept_value);
        errors++;
      end
      if (got.octal_as_decimal !== want.octal_as_decimal) begin
        $display("%0t: octal_as_decimal expected %0d actual %0d", $time,
                 want.octal_as_decimal, got.octal_as_decimal);
        errors++;
      end
      if (got.none_odd !== want.none_odd) begin
        $display("%0t: none_odd expected %0b actual %0b", $time, want.none_odd, got.none_odd);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $display("%0t: run_end expected %0b actual %0b", $time, want.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  sample_t           sample;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  odd_top_scoreboard  sb;
  bit                 quiet;
  bit                 hold_req;
  logic signed [31:0] last_value;
  int                 items_sent;

  top_k_odd_octal_select #(.MAX_KEEP(MAX_KEEP)) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) sb.note_sample(sample);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  task automatic send_sample(input logic signed [31:0] v, input logic fin);
    sample_t s;
    s.sample_value = v;
    s.final_item = fin;
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    items_sent++;
    last_value = v;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return $signed($urandom_range(0, 16)) - 8;
      4:       return last_value;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
  endtask

  task automatic send_random_run();
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    send_run(len);
  endtask

  task automatic wait_drained(input bit settle);
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_select_count(input logic [3:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SELECT_COUNT_ADDR;
    pwdata <= {28'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.select_count = val;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[3:0] !== val) begin
      $display("%0t: select_count readback expected %0d actual %0d", $time, val, prdata[3:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [3:0] counts [6];
    sb = new();
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    result_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    last_value = 0;
    items_sent = 0;
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd7};
    counts[4] = $urandom_range(2, 7);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset count: extremes and -1
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    send_sample(3, 1'b1);
    // only even values, with duplicates: empty result
    send_sample(4, 1'b0);
    send_sample(4, 1'b0);
    send_sample(-2, 1'b1);
    // single value, fewer loaded than the count
    send_sample(5, 1'b1);
    // overfill the list: small values fall off the end
    send_sample(9, 1'b0);
    send_sample(10, 1'b0);
    send_sample(8, 1'b0);
    send_sample(7, 1'b0);
    send_sample(6, 1'b0);
    send_sample(5, 1'b0);
    send_sample(4, 1'b0);
    send_sample(3, 1'b0);
    send_sample(1, 1'b0);
    send_sample(11, 1'b1);
    wait_drained(1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 5);
      write_select_count(counts[ph]);
      if (ph == 1) begin
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++) send_run($urandom_range(3, 8));
      end
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        send_random_run();
        if (!quiet && $urandom_range(0, 5) == 0) wait_drained(1'b0);
      end
      wait_drained(1'b1);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/tkoos_pkg.sv
src/tkoos_cell.sv
src/tkoos_octal.sv
src/top_k_odd_octal_select.sv
tb/top_k_odd_octal_select_tb.sv
